### rtl/abrs_pkg.sv
// Package for the aligned block range splitter.
// Payload structs, widths and queue depths shared by all rtl files.
// No dependencies.
package abrs_pkg;

    localparam int ADDR_WIDTH_DEF = 32;   // default address space, log2
    localparam int START_W        = 32;   // range_start / block_start width
    localparam int END_W          = 33;   // range_end / block_end width
    localparam int LOG_W          = 6;    // block_log_size width
    localparam int CMD_DEPTH      = 2;    // command queue between front and back
    localparam int RES_DEPTH      = 2;    // result queue on the output side

    // Input transaction
    typedef struct packed {
        logic [START_W-1:0] range_start;
        logic [END_W-1:0]   range_end;
    } t_range;

    // Result transaction
    typedef struct packed {
        logic [START_W-1:0] block_start;
        logic [END_W-1:0]   block_end;
        logic [LOG_W-1:0]   block_log_size;
        logic               last;
        logic               empty_range;
    } t_block;

    // Classified range, handed from front to back
    typedef struct packed {
        logic [END_W-1:0] cmd_start;
        logic [END_W-1:0] cmd_end;
        logic             is_empty;
    } t_cmd;

endpackage

### rtl/abrs_fifo.sv
// Small flop-based first-in first-out queue, generic width and depth.
// Used for the command queue and the result queue; uses abrs_pkg defaults.
// DEPTH must be a power of two, at least 2.
module abrs_fifo #(
    parameter int WIDTH = $bits(abrs_pkg::t_cmd),
    parameter int DEPTH = abrs_pkg::CMD_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt,  n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // Pointer and occupancy update
    always_comb begin
        n_wptr = wr_en ? r_wptr + PW'(1) : r_wptr;
        n_rptr = rd_en ? r_rptr + PW'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/abrs_front.sv
// Front end: accepts ranges, saturates them to the address space and
// flags empty ones, then queues them for the back end. Uses abrs_pkg, abrs_fifo.
module abrs_front #(
    parameter int ADDR_WIDTH = abrs_pkg::ADDR_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abrs_pkg::t_range i_range,
    output logic            o_full,
    input  logic            i_cmd_pop,
    output abrs_pkg::t_cmd  o_cmd,
    output logic            o_cmd_empty
);
    localparam int EW = abrs_pkg::END_W;

    logic [EW-1:0]  lim;
    logic [EW-1:0]  s_raw, e_raw, s_sat, e_sat;
    abrs_pkg::t_cmd cmd_in;
    logic [$bits(abrs_pkg::t_cmd)-1:0] cmd_out;

    // Saturate both ends to 2^ADDR_WIDTH and classify
    always_comb begin
        lim            = EW'(1) << ADDR_WIDTH;
        s_raw          = {1'b0, i_range.range_start};
        e_raw          = i_range.range_end;
        s_sat          = (s_raw > lim) ? lim : s_raw;
        e_sat          = (e_raw > lim) ? lim : e_raw;
        cmd_in.cmd_start = s_sat;
        cmd_in.cmd_end   = e_sat;
        cmd_in.is_empty  = (s_sat >= e_sat);
    end

    abrs_fifo #(
        .WIDTH ($bits(abrs_pkg::t_cmd)),
        .DEPTH (abrs_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_out),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = abrs_pkg::t_cmd'(cmd_out);

endmodule

### rtl/abrs_back.sv
// Back end: walks one range with a bit-position sequencer, first up through
// the cursor's alignment, then down through the remainder. Uses abrs_pkg, abrs_fifo.
module abrs_back #(
    parameter int ADDR_WIDTH = abrs_pkg::ADDR_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  abrs_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_empty,
    output logic            o_cmd_pop,
    input  logic            i_pop,
    output abrs_pkg::t_block o_block,
    output logic            o_empty
);
    localparam int EW = abrs_pkg::END_W;
    localparam int LW = abrs_pkg::LOG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ASC  = 2'd1;
    localparam logic [1:0] ST_DESC = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [EW-1:0] r_cur,   n_cur;
    logic [EW-1:0] r_end,   n_end;
    logic [LW-1:0] r_k,     n_k;

    logic             res_full;
    logic             res_push;
    abrs_pkg::t_block res_in;
    logic [$bits(abrs_pkg::t_block)-1:0] res_out;

    logic [EW-1:0] blk_len;
    logic [EW-1:0] nxt;
    logic          fits;
    logic          is_last;
    logic          aligned_here;

    // One candidate block of size 2^k at the cursor
    always_comb begin
        blk_len      = EW'(1) << r_k;
        nxt          = r_cur + blk_len;
        fits         = (nxt <= r_end);
        is_last      = (nxt == r_end);
        aligned_here = r_cur[r_k] || (r_k == LW'(ADDR_WIDTH));
    end

    // Sequencer: steps only while the result queue has room
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_end     = r_end;
        n_k       = r_k;
        o_cmd_pop = 1'b0;
        res_push  = 1'b0;

        res_in.block_start    = r_cur[abrs_pkg::START_W-1:0];
        res_in.block_end      = nxt;
        res_in.block_log_size = r_k;
        res_in.last           = is_last;
        res_in.empty_range    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && !res_full) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_empty) begin
                        // single flagged result
                        res_push              = 1'b1;
                        res_in.block_start    = '0;
                        res_in.block_end      = '0;
                        res_in.block_log_size = '0;
                        res_in.last           = 1'b1;
                        res_in.empty_range    = 1'b1;
                    end else begin
                        n_cur   = i_cmd.cmd_start;
                        n_end   = i_cmd.cmd_end;
                        n_k     = '0;
                        n_state = ST_ASC;
                    end
                end
            end
            ST_ASC: begin
                if (!res_full) begin
                    if (!fits) begin
                        // remainder below 2^k: sizes only shrink from here
                        n_k     = r_k - LW'(1);
                        n_state = ST_DESC;
                    end else if (aligned_here) begin
                        res_push = 1'b1;
                        n_cur    = nxt;
                        n_k      = r_k + LW'(1);
                        if (is_last) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_k = r_k + LW'(1);
                    end
                end
            end
            ST_DESC: begin
                if (!res_full) begin
                    if (fits) begin
                        res_push = 1'b1;
                        n_cur    = nxt;
                        if (is_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                    n_k = r_k - LW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_end <= n_end;
        r_k   <= n_k;
    end

    abrs_fifo #(
        .WIDTH ($bits(abrs_pkg::t_block)),
        .DEPTH (abrs_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_empty (o_empty)
    );

    assign o_block = abrs_pkg::t_block'(res_out);

endmodule

### rtl/aligned_block_range_splitter_unit.sv
// Top level of the aligned block range splitter.
// Instantiates abrs_front and abrs_back; types from abrs_pkg.
//
//   Channel   Direction  Handshake            Payload
//   range     in         push / full          i_range  (abrs_pkg::t_range)
//   block     out        empty / pop          o_block  (abrs_pkg::t_block)
//
// An empty range yields one flagged result. A nonempty range is loaded, then the
// sequencer walks the bit positions, climbing through the cursor's alignment
// and then descending through the remainder.
// A two-entry command queue takes new ranges while one is being split.
// Reset is synchronous, active low; both queues come up empty.
// The sequencer holds whenever the two-entry result queue is full.
module aligned_block_range_splitter_unit #(
    parameter int ADDR_WIDTH = abrs_pkg::ADDR_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  abrs_pkg::t_range i_range,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output abrs_pkg::t_block o_block
);
    abrs_pkg::t_cmd cmd;
    logic           cmd_empty;
    logic           cmd_pop;

    abrs_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_range     (i_range),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    abrs_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_block     (o_block),
        .o_empty     (empty)
    );

    // Checks on delivered transactions and on the reset state
    a_empty_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_block.empty_range) |->
            (o_block.last && o_block.block_end == '0 && o_block.block_log_size == '0))
        else $error("flagged empty range result malformed");

    a_block_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_block.empty_range) |->
            (o_block.block_end ==
             ({1'b0, o_block.block_start} +
              (abrs_pkg::END_W'(1) << o_block.block_log_size))))
        else $error("block end does not match its size");

    a_block_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_block.empty_range) |->
            ((({1'b0, o_block.block_start}) &
              ((abrs_pkg::END_W'(1) << o_block.block_log_size) -
               abrs_pkg::END_W'(1))) == '0))
        else $error("block start not aligned to its size");

    a_log_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_block.block_log_size <= abrs_pkg::LOG_W'(ADDR_WIDTH)))
        else $error("block size exceeds address space");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

### bench/abrs_block_checker.sv
// Checker for the aligned block range splitter: watches both queue ports,
// predicts the block sequence of every accepted range and compares results.
// Depends on abrs_pkg for the payload structs and field widths.
module abrs_block_checker #(
    parameter int ADDR_WIDTH = abrs_pkg::ADDR_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  abrs_pkg::t_range i_range,
    input  logic             i_empty,
    input  logic             i_pop,
    input  abrs_pkg::t_block i_block,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_block_count,
    output int               o_empty_count,
    output int               o_longest_split
);
    timeunit 1ns;
    timeprecision 1ps;

    import abrs_pkg::*;

    localparam int MAX_SPLIT = 64;

    t_block expected_blocks[$];
    int     mismatch_count = 0;
    int     blocks_checked = 0;
    int     empty_ranges   = 0;
    int     longest_split  = 0;

    // Greedy aligned cover of one range, appended to the expected queue
    function automatic void split_range(input t_range r);
        logic [63:0] space_top;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] cursor;
        logic [63:0] left;
        logic [63:0] step;
        int unsigned k;
        int          n;
        t_block      blk;
        space_top = 64'd1 << ADDR_WIDTH;
        lo = 64'(r.range_start);
        hi = 64'(r.range_end);
        if (lo > space_top) lo = space_top;
        if (hi > space_top) hi = space_top;

        // empty or inverted range: a single flagged result
        if (lo >= hi) begin
            blk = '0;
            blk.last = 1'b1;
            blk.empty_range = 1'b1;
            expected_blocks.push_back(blk);
            return;
        end

        cursor = lo;
        n = 0;
        while (cursor < hi && n < MAX_SPLIT) begin
            left = hi - cursor;
            k = 0;
            // grow while the cursor stays aligned and the block still fits
            while (k < ADDR_WIDTH) begin
                step = 64'd1 << (k + 1);
                if ((cursor & (step - 64'd1)) != 64'd0 || step > left) break;
                k++;
            end
            step = 64'd1 << k;
            blk.block_start    = cursor[START_W-1:0];
            blk.block_end      = END_W'(cursor + step);
            blk.block_log_size = LOG_W'(k);
            blk.last           = (cursor + step >= hi) || (n == MAX_SPLIT - 1);
            blk.empty_range    = 1'b0;
            expected_blocks.push_back(blk);
            cursor = cursor + step;
            n++;
        end
        if (n > longest_split) longest_split = n;
    endfunction

    // Compare one popped block with the oldest expectation
    task automatic check_block(input t_block got);
        t_block want;
        if (expected_blocks.size() == 0) begin
            if (mismatch_count < 10)
                $display("[%0t] unexpected block: start=%h end=%h log=%0d last=%b empty=%b",
                         $realtime, got.block_start, got.block_end,
                         got.block_log_size, got.last, got.empty_range);
            mismatch_count++;
            return;
        end
        want = expected_blocks.pop_front();
        blocks_checked++;
        if (got.empty_range) empty_ranges++;
        if (got.block_start != want.block_start || got.block_end != want.block_end
            || got.block_log_size != want.block_log_size || got.last != want.last
            || got.empty_range != want.empty_range) begin
            if (mismatch_count < 10) begin
                $display("[%0t] block mismatch #%0d", $realtime, blocks_checked);
                $display("  expected start=%h end=%h log=%0d last=%b empty=%b",
                         want.block_start, want.block_end, want.block_log_size,
                         want.last, want.empty_range);
                $display("  actual   start=%h end=%h log=%0d last=%b empty=%b",
                         got.block_start, got.block_end, got.block_log_size,
                         got.last, got.empty_range);
            end
            mismatch_count++;
        end
    endtask

    // Monitor: results are checked before the same-edge range is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !i_empty) check_block(i_block);
            if (i_push && !i_full) split_range(i_range);
        end
        o_pending <= expected_blocks.size();
    end

    assign o_fail_count    = mismatch_count;
    assign o_block_count   = blocks_checked;
    assign o_empty_count   = empty_ranges;
    assign o_longest_split = longest_split;

endmodule

### bench/aligned_block_range_splitter_unit_test.sv
// Testbench top for aligned_block_range_splitter_unit: clock, reset, range
// stimulus with random idling on both sides, and the final verdict.
// Depends on abrs_pkg, the block's rtl and bench/abrs_block_checker.sv.
module aligned_block_range_splitter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import abrs_pkg::*;

    localparam int ADDR_WIDTH   = ADDR_WIDTH_DEF;
    localparam int RANDOM_RANGES = 242;
    localparam int CALM_RANGES   = 40;
    localparam int DRAIN_CYCLES  = 2 * ADDR_WIDTH + 8;

    logic   i_clk;
    logic   i_rst_n = 1'b0;
    logic   push = 1'b0;
    logic   full;
    logic   empty;
    logic   pop = 1'b0;
    t_range range_in = '0;
    t_block block_out;

    logic   calm = 1'b0;
    int     pop_hold = 0;
    int     ranges_sent = 0;

    int     fail_count;
    int     pending;
    int     block_count;
    int     empty_count;
    int     longest_split;

    aligned_block_range_splitter_unit #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_range (range_in),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_block (block_out)
    );

    abrs_block_checker #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_range         (range_in),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_block         (block_out),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_block_count   (block_count),
        .o_empty_count   (empty_count),
        .o_longest_split (longest_split)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Result side: pop with random stall bursts
    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (!calm && $urandom_range(7, 0) == 0) begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(17, 0);
        end else begin
            pop <= 1'b1;
        end
    end

    // Hold push low for a random burst now and then
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(4, 0) == 0) begin
            n = $urandom_range(18, 1);
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Offer one range and wait until the block takes the transaction
    task automatic send_range(input logic [START_W-1:0] s, input logic [END_W-1:0] e);
        sender_gap();
        push <= 1'b1;
        range_in.range_start <= s;
        range_in.range_end <= e;
        do @(posedge i_clk); while (full);
        ranges_sent++;
    endtask

    // Random range, mostly well formed, with empty, inverted and oversized ones
    task automatic send_random_range();
        logic [START_W-1:0] s;
        logic [END_W-1:0]   e;
        logic [END_W-1:0]   a;
        logic [END_W-1:0]   b;
        logic [31:0]        mask;
        int                 sel;
        int                 k;
        sel = $urandom_range(99, 0);
        s = $urandom;
        if (sel < 10) begin
            // empty or inverted
            e = {1'b0, 32'($urandom_range(s, 0))};
        end else if (sel < 45) begin
            // short range from a random cursor
            e = {1'b0, s} + END_W'($urandom_range(300, 1));
        end else if (sel < 65) begin
            // aligned start, length up to a few blocks of that size
            k = $urandom_range(31, 0);
            mask = (32'd1 << k) - 32'd1;
            s = s & ~mask;
            e = {1'b0, s} + END_W'(($urandom & mask) + 32'd1)
                + (END_W'($urandom_range(3, 0)) << k);
        end else if (sel < 85) begin
            // two random points, ordered
            a = {1'b0, s};
            b = {$urandom_range(1, 0) == 0 ? 1'b0 : 1'b1, 32'($urandom)};
            if (b[END_W-1]) b[END_W-1] = ($urandom_range(3, 0) == 0);
            if (a < b) e = b;
            else if (a > b) begin
                s = b[START_W-1:0];
                e = a;
            end else e = a + END_W'(1);
        end else begin
            // end beyond the address space, saturated
            e = {1'b1, 32'($urandom)};
        end
        send_range(s, e);
    endtask

    // Stimulus and verdict
    initial begin
        int i;
        range_in = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, empty and inverted ranges, saturation, longest split
        send_range(32'h0000_0000, 33'h1_0000_0000);
        send_range(32'h0000_0000, 33'h0_0000_0000);
        send_range(32'h0000_0005, 33'h0_0000_0003);
        send_range(32'hFFFF_FFFF, 33'h1_0000_0000);
        send_range(32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
        send_range(32'h0000_0000, 33'h0_0000_0001);
        send_range(32'h0000_0001, 33'h1_0000_0000);
        send_range(32'h0000_0001, 33'h0_FFFF_FFFF);
        send_range(32'h8000_0000, 33'h1_0000_0000);
        send_range(32'h7FFF_FFFF, 33'h0_8000_0001);
        send_range(32'hFFFF_FFFF, 33'h0_FFFF_FFFF);
        send_range(32'hFFFF_FFFF, 33'h0_0000_0000);
        send_range(32'hAAAA_AAAA, 33'h1_5555_5555);
        send_range(32'h5555_5555, 33'h0_AAAA_AAAA);
        send_range(32'h0000_0000, 33'h1_FFFF_FFFF);
        send_range(32'h0000_1000, 33'h0_0000_2000);
        send_range(32'h0000_0003, 33'h0_0000_0004);
        send_range(32'h1234_5678, 33'h0_1234_5679);

        // let the block run dry before the random part
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        for (i = 0; i < RANDOM_RANGES; i++) begin
            if (i == RANDOM_RANGES - CALM_RANGES) calm <= 1'b1;
            send_random_range();
        end
        push <= 1'b0;

        // drain
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d ranges (%0d empty or inverted), %0d blocks checked,",
                 ranges_sent, empty_count, block_count);
        $display("longest split %0d blocks, %0d mismatches.", longest_split, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/abrs_pkg.sv
rtl/abrs_fifo.sv
rtl/abrs_front.sv
rtl/abrs_back.sv
rtl/aligned_block_range_splitter_unit.sv
bench/abrs_block_checker.sv
bench/aligned_block_range_splitter_unit_test.sv
